// ----- rtl/rgb_to_ycbcr_422_filtered_unit_macros.svh -----
// ----------------------------------------------------------------------------
// RGB to 4:2:2 YCbCr converter: assertion macros
// Shared property wrappers on clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YCBCR_422_FILTERED_UNIT_MACROS_SVH
`define RGB_TO_YCBCR_422_FILTERED_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RYC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RYC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ryc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to 4:2:2 YCbCr converter: package
// Widths, fixed-point coefficients and the word types shared by all modules.
// ----------------------------------------------------------------------------
package ryc_pkg;

  // Longest scan line; the pixel at MAX_LINE-1 always ends the line
  localparam int MAX_LINE = 1024;
  localparam int POS_W    = $clog2(MAX_LINE);

  // Fixed point: Q14 coefficients, Q8 samples, Q22 filter sums
  localparam int MCOEF_W    = 15;
  localparam int FCOEF_W    = 16;
  localparam int MAT_W      = 24;
  localparam int SAMPLE_W   = 18;
  localparam int PROD_W     = SAMPLE_W + FCOEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int MAT_SHIFT  = 6;
  localparam int OUT_SHIFT  = 22;
  localparam int PIX_MAX    = 255;

  localparam int CHANS = 3;
  localparam int TAPS  = 5;
  localparam int WIN   = TAPS - 1;
  localparam int STEPS = 3;

  // Step indexes within one queued word
  localparam logic [1:0] STEP_FIRST = 2'd0;
  localparam logic [1:0] STEP_FINAL = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

  typedef logic signed [MCOEF_W-1:0]  mcoef_t;
  typedef logic signed [FCOEF_W-1:0]  fcoef_t;
  typedef logic signed [MAT_W-1:0]    mat_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Colour matrix rows, red / green / blue order
  localparam mcoef_t MAT_Y [CHANS] = '{15'sd4899, 15'sd9617, 15'sd1868};
  localparam mcoef_t MAT_U [CHANS] = '{-15'sd2762, -15'sd5425, 15'sd8187};
  localparam mcoef_t MAT_V [CHANS] = '{15'sd8189, -15'sd6857, -15'sd1332};

  // Sharpening kernel for luma, smoothing kernel for chroma
  localparam fcoef_t FILT_Y [TAPS] =
    '{-16'sd798, 16'sd265, 16'sd15138, 16'sd265, -16'sd798};
  localparam fcoef_t FILT_C [TAPS] =
    '{16'sd2154, 16'sd3168, 16'sd3750, 16'sd3168, 16'sd2154};

  localparam acc_t LUMA_OFS   = ACC_W'(16 * (2 ** OUT_SHIFT));
  localparam acc_t CHROMA_OFS = ACC_W'(128 * (2 ** OUT_SHIFT));

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] chroma;
    logic [7:0] luma;
    logic       odd_pixel;
    logic       line_last;
    logic       run_last;
  } result_t;

  // One classified pixel: samples plus per-step emit, parity and tail marks
  typedef struct packed {
    sample_t          y;
    sample_t          u;
    sample_t          v;
    logic             last;
    logic [STEPS-1:0] emit;
    logic [STEPS-1:0] odd;
    logic [STEPS-1:0] tail;
  } entry_t;

endpackage

// ----- rtl/ryc_front.sv -----
// ----------------------------------------------------------------------------
// RGB to 4:2:2 YCbCr converter: front end
// Accepts pixels, tracks the line position, decides which filter steps emit
// and applies the colour matrix before handing the word to the step queue.
// ----------------------------------------------------------------------------
module ryc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  ryc_pkg::pixel_t pixel,
  output logic            q_push,
  output ryc_pkg::entry_t q_entry,
  input  logic            q_full
);
  import ryc_pkg::*;

  logic             f_valid;
  logic [POS_W-1:0] pos;
  mat_t             f_py [CHANS];
  mat_t             f_pu [CHANS];
  mat_t             f_pv [CHANS];
  logic             f_last;
  logic [STEPS-1:0] f_emit;
  logic [STEPS-1:0] f_odd;
  logic [STEPS-1:0] f_tail;

  logic                accept;
  logic                last_now;
  logic signed [8:0]   chan [CHANS];
  logic [STEPS-1:0]    emit_now;
  logic [STEPS-1:0]    odd_now;
  logic [STEPS-1:0]    tail_now;
  mat_t                sum_y;
  mat_t                sum_u;
  mat_t                sum_v;

  // Handshake: the stage register holds one pixel until the queue takes it
  assign full   = f_valid && q_full;
  assign accept = push && !full;
  assign q_push = f_valid && !q_full;

  // Classify the pixel against its line position
  always_comb begin
    chan[0]  = $signed({1'b0, pixel.red});
    chan[1]  = $signed({1'b0, pixel.green});
    chan[2]  = $signed({1'b0, pixel.blue});
    last_now = pixel.line_end || (pos == POS_W'(MAX_LINE - 1));
    emit_now[0] = pos > POS_W'(1);
    emit_now[1] = last_now && (pos != '0);
    emit_now[2] = last_now && pos[0];
    odd_now[0]  = pos[0];
    odd_now[1]  = ~pos[0];
    odd_now[2]  = 1'b1;
    tail_now[2] = emit_now[2];
    tail_now[1] = emit_now[1] && !emit_now[2];
    tail_now[0] = emit_now[0] && !emit_now[1] && !emit_now[2];
  end

  // Hold the valid flag and advance or restart the line position
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      pos     <= '0;
    end else if (accept) begin
      f_valid <= 1'b1;
      pos     <= last_now ? '0 : pos + POS_W'(1);
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  // Register the matrix products and step marks
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CHANS; i++) begin
        f_py[i] <= MAT_W'(chan[i]) * MAT_W'(MAT_Y[i]);
        f_pu[i] <= MAT_W'(chan[i]) * MAT_W'(MAT_U[i]);
        f_pv[i] <= MAT_W'(chan[i]) * MAT_W'(MAT_V[i]);
      end
      f_last <= last_now;
      f_emit <= emit_now;
      f_odd  <= odd_now;
      f_tail <= tail_now;
    end
  end

  // Sum the rows and floor to Q8 samples
  always_comb begin
    sum_y = f_py[0] + f_py[1] + f_py[2];
    sum_u = f_pu[0] + f_pu[1] + f_pu[2];
    sum_v = f_pv[0] + f_pv[1] + f_pv[2];
    q_entry.y    = SAMPLE_W'(sum_y >>> MAT_SHIFT);
    q_entry.u    = SAMPLE_W'(sum_u >>> MAT_SHIFT);
    q_entry.v    = SAMPLE_W'(sum_v >>> MAT_SHIFT);
    q_entry.last = f_last;
    q_entry.emit = f_emit;
    q_entry.odd  = f_odd;
    q_entry.tail = f_tail;
  end

endmodule

// ----- rtl/ryc_step_queue.sv -----
// ----------------------------------------------------------------------------
// RGB to 4:2:2 YCbCr converter: step queue
// Short first-in first-out buffer of classified pixels between the front end
// and the filter back end.
// ----------------------------------------------------------------------------
module ryc_step_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ryc_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            rd,
  output ryc_pkg::entry_t rd_entry,
  output logic            empty
);
  import ryc_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_wr    = wr && !full;
  assign do_rd    = rd && !empty;
  assign rd_entry = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

// ----- rtl/ryc_back.sv -----
// ----------------------------------------------------------------------------
// RGB to 4:2:2 YCbCr converter: filter back end
// Runs the filter steps of each queued pixel through a two-stage pipeline
// (tap products, then sum and saturate) and buffers the result words.
// ----------------------------------------------------------------------------
`include "rgb_to_ycbcr_422_filtered_unit_macros.svh"

module ryc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  ryc_pkg::entry_t  q_entry,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output ryc_pkg::result_t result
);
  import ryc_pkg::*;

  // Step sequencing
  logic [1:0]  step_idx;
  logic [1:0]  last_step;
  logic        issue;
  logic        first;
  logic        clear_now;
  sample_t     s_y;
  sample_t     s_u;
  sample_t     s_v;

  // Tap windows
  sample_t     win_y  [WIN];
  sample_t     win_cb [WIN];
  sample_t     win_cr [WIN];

  // Product stage
  logic        p_valid;
  logic        p_emit;
  logic        p_odd;
  logic        p_run_last;
  logic        p_line_last;
  logic        p_clear;
  prod_t       p_y  [TAPS];
  prod_t       p_cb [TAPS];
  prod_t       p_cr [TAPS];

  // Sum stage
  acc_t        acc_y;
  acc_t        acc_cb;
  acc_t        acc_cr;
  logic [7:0]  luma_sat;
  logic [7:0]  cb_sat;
  logic [7:0]  cr_sat;
  logic [7:0]  held_cr;
  result_t     out_word;

  // Result buffer
  result_t           out_mem [OUT_DEPTH];
  logic [OPTR_W-1:0] wr_ptr;
  logic [OPTR_W-1:0] rd_ptr;
  logic [OCNT_W-1:0] out_count;
  logic              out_wr;
  logic              out_rd;

  function automatic logic [7:0] sat8(input acc_t a);
    logic [ACC_W-OUT_SHIFT-1:0] hi;
    hi = a[ACC_W-1:OUT_SHIFT];
    if (a[ACC_W-1]) begin
      return '0;
    end else if (hi > (ACC_W - OUT_SHIFT)'(PIX_MAX)) begin
      return 8'(PIX_MAX);
    end else begin
      return hi[7:0];
    end
  endfunction

  // Issue a step only when the result buffer can take everything in flight
  always_comb begin
    last_step = q_entry.last ? STEP_FINAL : STEP_FIRST;
    issue     = !q_empty && ((out_count + OCNT_W'(p_valid)) < OCNT_W'(OUT_DEPTH));
    q_pop     = issue && (step_idx == last_step);
    first     = step_idx == STEP_FIRST;
    clear_now = q_entry.last && (step_idx == STEP_FINAL);
    s_y       = first ? q_entry.y : '0;
    s_u       = first ? q_entry.u : '0;
    s_v       = first ? q_entry.v : '0;
  end

  // Advance steps, shift or clear the windows, hold the Cr for the odd pixel, move the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      step_idx  <= STEP_FIRST;
      p_valid   <= 1'b0;
      held_cr   <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
      for (int i = 0; i < WIN; i++) begin
        win_y[i]  <= '0;
        win_cb[i] <= '0;
        win_cr[i] <= '0;
      end
    end else begin
      p_valid <= issue;
      if (issue) begin
        step_idx <= q_pop ? STEP_FIRST : step_idx + 2'd1;
        if (clear_now) begin
          for (int i = 0; i < WIN; i++) begin
            win_y[i]  <= '0;
            win_cb[i] <= '0;
            win_cr[i] <= '0;
          end
        end else begin
          for (int i = 0; i < WIN - 1; i++) begin
            win_y[i]  <= win_y[i+1];
            win_cb[i] <= win_cb[i+1];
            win_cr[i] <= win_cr[i+1];
          end
          win_y[WIN-1]  <= s_y;
          win_cb[WIN-1] <= s_u;
          win_cr[WIN-1] <= s_v;
        end
      end
      if (p_valid && p_clear) begin
        held_cr <= '0;
      end else if (p_valid && p_emit && !p_odd) begin
        held_cr <= cr_sat;
      end
      if (out_wr) begin
        wr_ptr <= (wr_ptr == OPTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + OPTR_W'(1);
      end
      if (out_rd) begin
        rd_ptr <= (rd_ptr == OPTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + OPTR_W'(1);
      end
      if (out_wr && !out_rd) begin
        out_count <= out_count + OCNT_W'(1);
      end else if (out_rd && !out_wr) begin
        out_count <= out_count - OCNT_W'(1);
      end
    end
  end

  // Register the tap products and step marks
  always_ff @(posedge clk) begin
    if (issue) begin
      for (int i = 0; i < WIN; i++) begin
        p_y[i]  <= PROD_W'(FILT_Y[i]) * PROD_W'(win_y[i]);
        p_cb[i] <= PROD_W'(FILT_C[i]) * PROD_W'(win_cb[i]);
        p_cr[i] <= PROD_W'(FILT_C[i]) * PROD_W'(win_cr[i]);
      end
      p_y[TAPS-1]  <= PROD_W'(FILT_Y[TAPS-1]) * PROD_W'(s_y);
      p_cb[TAPS-1] <= PROD_W'(FILT_C[TAPS-1]) * PROD_W'(s_u);
      p_cr[TAPS-1] <= PROD_W'(FILT_C[TAPS-1]) * PROD_W'(s_v);
      p_emit      <= q_entry.emit[step_idx];
      p_odd       <= q_entry.odd[step_idx];
      p_run_last  <= q_entry.tail[step_idx];
      p_line_last <= q_entry.last && q_entry.tail[step_idx];
      p_clear     <= clear_now;
    end
  end

  // Sum the taps, add the offsets, saturate
  always_comb begin
    acc_y  = LUMA_OFS;
    acc_cb = CHROMA_OFS;
    acc_cr = CHROMA_OFS;
    for (int i = 0; i < TAPS; i++) begin
      acc_y  = acc_y + ACC_W'(p_y[i]);
      acc_cb = acc_cb + ACC_W'(p_cb[i]);
      acc_cr = acc_cr + ACC_W'(p_cr[i]);
    end
    luma_sat = sat8(acc_y);
    cb_sat   = sat8(acc_cb);
    cr_sat   = sat8(acc_cr);
    out_word.chroma    = p_odd ? held_cr : cb_sat;
    out_word.luma      = luma_sat;
    out_word.odd_pixel = p_odd;
    out_word.line_last = p_line_last;
    out_word.run_last  = p_run_last;
  end

  assign out_wr = p_valid && p_emit;
  assign out_rd = pop && !empty;
  assign empty  = out_count == '0;
  assign result = out_mem[rd_ptr];

  // Store finished result words
  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_mem[wr_ptr] <= out_word;
    end
  end

  `RYC_ASSERT(a_out_bound, out_count <= OCNT_W'(OUT_DEPTH), "result buffer overrun")
  `RYC_ASSERT(a_line_last_tail, (p_valid && p_line_last) |-> p_run_last, "line end not on run end")
  `RYC_ASSERT(a_cr_cleared, (p_valid && p_clear) |=> (held_cr == '0), "held Cr not cleared at line end")
  `RYC_ASSERT(a_win_cleared, (p_valid && p_clear) |-> (win_y[0] == '0 && win_cb[0] == '0 && win_cr[0] == '0), "windows not cleared at line end")

endmodule

// ----- rtl/rgb_to_ycbcr_422_filtered_unit.sv -----
// Path: a pixel passes the front-end register, step queue, tap products and result
// buffer. Throughput: one pixel per cycle unless a queue is full; a line-end pixel
// takes three filter steps, one per cycle, in the shared two-stage filter pipeline.
// Reset (synchronous, rst high): clears the line position, tap windows, held Cr and
// both queues; no clearing pass, so pixels are taken on the first cycle after reset.
// ----------------------------------------------------------------------------
// RGB to 4:2:2 YCbCr converter with 5-tap filtering
// Front end classifies pixels and applies the colour matrix, a short queue
// decouples it from the filter back end that produces the 4:2:2 words.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_422_filtered_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  ryc_pkg::pixel_t  pixel,
  output logic             empty,
  input  logic             pop,
  output ryc_pkg::result_t result
);
  import ryc_pkg::*;

  logic   fq_push;
  logic   fq_full;
  entry_t fq_entry;
  logic   qb_pop;
  logic   qb_empty;
  entry_t qb_entry;

  // Accept and classify
  ryc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .q_push  (fq_push),
    .q_entry (fq_entry),
    .q_full  (fq_full)
  );

  // Decouple front and back
  ryc_step_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (fq_push),
    .wr_entry (fq_entry),
    .full     (fq_full),
    .rd       (qb_pop),
    .rd_entry (qb_entry),
    .empty    (qb_empty)
  );

  // Filter and emit
  ryc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (qb_empty),
    .q_entry (qb_entry),
    .q_pop   (qb_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
